// ===== hdl/isq_pkg.sv =====
// isq_pkg: shared constants, request codes and types of the indexed sequence store
// used by isq_cell, isq_find and indexed_sequence_store; depends on nothing
package isq_pkg;

    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int FIELD_W  = 7;
    localparam int CMP_W    = (CNT_W > FIELD_W) ? CNT_W : FIELD_W;
    localparam int GRP      = 8;
    localparam int NGRP     = (CAPACITY + GRP - 1) / GRP;
    localparam int LOC_W    = $clog2(GRP);

    // request codes
    localparam logic [2:0] REQ_INS_FRONT = 3'd0;
    localparam logic [2:0] REQ_INS_BACK  = 3'd1;
    localparam logic [2:0] REQ_INS_AT    = 3'd2;
    localparam logic [2:0] REQ_FIND      = 3'd3;
    localparam logic [2:0] REQ_REMOVE_AT = 3'd4;
    localparam logic [2:0] REQ_POP_FRONT = 3'd5;
    localparam logic [2:0] REQ_POP_BACK  = 3'd6;
    localparam logic [2:0] REQ_CLEAR     = 3'd7;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    localparam logic [FIELD_W-1:0] NO_POS = 7'h7F;

    // cell operations
    localparam logic [1:0] OP_NONE = 2'd0;
    localparam logic [1:0] OP_INS  = 2'd1;
    localparam logic [1:0] OP_REM  = 2'd2;

    typedef struct packed {
        logic              go;
        logic [1:0]        op;
        logic [CMP_W-1:0]  pos;
        logic [CMP_W-1:0]  occ;
        logic [DATA_W-1:0] value;
    } cell_req_t;

    function automatic logic [FIELD_W-1:0] fit_cnt(input logic [CNT_W-1:0] c);
        logic [CNT_W+FIELD_W-1:0] t;
        t = (CNT_W + FIELD_W)'(c);
        return t[FIELD_W-1:0];
    endfunction

    function automatic logic [FIELD_W-1:0] fit_idx(input logic [IDX_W-1:0] c);
        logic [IDX_W+FIELD_W-1:0] t;
        t = (IDX_W + FIELD_W)'(c);
        return t[FIELD_W-1:0];
    endfunction

endpackage

// ===== hdl/isq_cell.sv =====
// isq_cell: one storage cell of the chain, shifting with its neighbours and comparing
// depends on isq_pkg
module isq_cell (
    input  logic                       clk,
    input  logic [isq_pkg::IDX_W-1:0]  idx,
    input  isq_pkg::cell_req_t         req,
    input  logic [isq_pkg::DATA_W-1:0] prev_data,
    input  logic [isq_pkg::DATA_W-1:0] next_data,
    output logic [isq_pkg::DATA_W-1:0] data,
    output logic                       match
);
    import isq_pkg::*;

    logic [DATA_W-1:0] data_reg;
    logic              match_reg;
    logic [CMP_W-1:0]  idx_ext;

    assign idx_ext = CMP_W'(idx);

    always_ff @(posedge clk)
    begin
        if (req.go)
        begin
            match_reg <= (data_reg == req.value) && (idx_ext < req.occ);
            case (req.op)
                OP_INS:
                begin
                    if (idx_ext == req.pos)
                        data_reg <= req.value;
                    else if (idx_ext > req.pos)
                        data_reg <= prev_data;
                end
                OP_REM:
                begin
                    if (idx_ext >= req.pos)
                        data_reg <= next_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign data  = data_reg;
    assign match = match_reg;

endmodule

// ===== hdl/isq_find.sv =====
// isq_find: two-level first-match search over the match bits of the cell chain
// depends on isq_pkg
module isq_find (
    input  logic                          clk,
    input  logic [isq_pkg::CAPACITY-1:0]  match,
    output logic                          hit,
    output logic [isq_pkg::IDX_W-1:0]     hit_idx
);
    import isq_pkg::*;

    logic [NGRP*GRP-1:0] match_pad;
    logic [NGRP-1:0]     grp_hit_next;
    logic [LOC_W-1:0]    grp_loc_next [NGRP];
    logic [NGRP-1:0]     grp_hit_reg;
    logic [LOC_W-1:0]    grp_loc_reg  [NGRP];

    assign match_pad = (NGRP * GRP)'(match);

    // lowest set bit within each group of eight
    always_comb
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            grp_hit_next[g] = 1'b0;
            grp_loc_next[g] = '0;
            for (int b = GRP - 1; b >= 0; b--)
            begin
                if (match_pad[g*GRP + b])
                begin
                    grp_hit_next[g] = 1'b1;
                    grp_loc_next[g] = LOC_W'(b);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        grp_hit_reg <= grp_hit_next;
        for (int g = 0; g < NGRP; g++)
            grp_loc_reg[g] <= grp_loc_next[g];
    end

    // lowest group with a hit
    always_comb
    begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int g = NGRP - 1; g >= 0; g--)
        begin
            if (grp_hit_reg[g])
            begin
                hit     = 1'b1;
                hit_idx = IDX_W'(g * GRP) + IDX_W'(grp_loc_reg[g]);
            end
        end
    end

endmodule

// ===== hdl/indexed_sequence_store.sv =====
// indexed_sequence_store: bounded ordered sequence of signed 32-bit values
// depends on isq_pkg, isq_cell and isq_find
//
// usage
//   requests come in on s_tvalid/s_tready; s_tuser carries the request kind and
//   s_tdata the position and value. each request gives one result on
//   m_tvalid/m_tready with status, found position, count and empty flag.
//   the values sit in a row of cells; an insert or remove moves every cell
//   behind the position one place at once, and a find compares all
//   cells in parallel.
//   path: an accepted request reaches its result in the output register through
//   cell update and compare, then group search, then final pick.
//   flow: a new request is taken only once the previous one has left the final
//   pick stage; it is taken while the previous result still waits.
//   if the receiver stalls, the result holds in the output register and a
//   further request waits in the final pick stage until the register frees.
//   reset empties the store and drops any pending result; cell contents are
//   not cleared.
module indexed_sequence_store (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // position[6:0], value[38:7], zero fill
    input  logic [2:0]  s_tuser,  // req_type[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata   // status[1:0], found_position[8:2], count[15:9],
                                  // empty_flag[16], zero fill
);
    import isq_pkg::*;

    localparam logic [1:0] S_IDLE    = 2'd0;
    localparam logic [1:0] S_GROUP   = 2'd1;
    localparam logic [1:0] S_RESOLVE = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  occ_reg, occ_next;
    logic [1:0]        pend_status_reg, status_next;
    logic              pend_find_reg;
    logic              m_tvalid_reg;
    logic [23:0]       m_tdata_reg;

    logic              accept;
    logic              out_free;
    logic [6:0]        in_pos;
    logic [DATA_W-1:0] in_value;
    logic [CMP_W-1:0]  occ_ext, pos_ext;
    logic              full, empty;
    logic [1:0]        op;
    logic [CMP_W-1:0]  op_pos;
    cell_req_t         creq;

    logic [DATA_W-1:0]   cell_data [CAPACITY];
    logic [CAPACITY-1:0] cell_match;
    logic                hit;
    logic [IDX_W-1:0]    hit_idx;
    logic [FIELD_W-1:0]  found;
    logic [FIELD_W-1:0]  cnt_out;

    assign in_pos   = s_tdata[6:0];
    assign in_value = s_tdata[38:7];
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign occ_ext = CMP_W'(occ_reg);
    assign pos_ext = CMP_W'(in_pos);
    assign full    = (occ_reg == CNT_W'(CAPACITY));
    assign empty   = (occ_reg == '0);

    // request decode
    always_comb
    begin
        status_next = ST_OK;
        occ_next    = occ_reg;
        op          = OP_NONE;
        op_pos      = '0;
        unique case (s_tuser)
            REQ_INS_FRONT:
            begin
                if (full)
                    status_next = ST_FULL;
                else
                begin
                    op       = OP_INS;
                    occ_next = occ_reg + 1'b1;
                end
            end
            REQ_INS_BACK:
            begin
                if (full)
                    status_next = ST_FULL;
                else
                begin
                    op       = OP_INS;
                    op_pos   = occ_ext;
                    occ_next = occ_reg + 1'b1;
                end
            end
            REQ_INS_AT:
            begin
                if (pos_ext > occ_ext)
                    status_next = ST_RANGE;
                else if (full)
                    status_next = ST_FULL;
                else
                begin
                    op       = OP_INS;
                    op_pos   = pos_ext;
                    occ_next = occ_reg + 1'b1;
                end
            end
            REQ_FIND:
            begin
            end
            REQ_REMOVE_AT:
            begin
                if (empty)
                    status_next = ST_EMPTY;
                else if (pos_ext >= occ_ext)
                    status_next = ST_RANGE;
                else
                begin
                    op       = OP_REM;
                    op_pos   = pos_ext;
                    occ_next = occ_reg - 1'b1;
                end
            end
            REQ_POP_FRONT:
            begin
                if (empty)
                    status_next = ST_EMPTY;
                else
                begin
                    op       = OP_REM;
                    occ_next = occ_reg - 1'b1;
                end
            end
            REQ_POP_BACK:
            begin
                if (empty)
                    status_next = ST_EMPTY;
                else
                    occ_next = occ_reg - 1'b1;
            end
            REQ_CLEAR:
            begin
                occ_next = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        creq.go    = accept;
        creq.op    = accept ? op : OP_NONE;
        creq.pos   = op_pos;
        creq.occ   = occ_ext;
        creq.value = in_value;
    end

    // cell chain
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DATA_W-1:0] prev_d, next_d;
        if (i == 0)
        begin : g_first
            assign prev_d = '0;
        end
        else
        begin : g_mid_prev
            assign prev_d = cell_data[i-1];
        end
        if (i == CAPACITY - 1)
        begin : g_last
            assign next_d = '0;
        end
        else
        begin : g_mid_next
            assign next_d = cell_data[i+1];
        end
        isq_cell u_cell (
            .clk       (clk),
            .idx       (IDX_W'(i)),
            .req       (creq),
            .prev_data (prev_d),
            .next_data (next_d),
            .data      (cell_data[i]),
            .match     (cell_match[i])
        );
    end

    isq_find u_find (
        .clk     (clk),
        .match   (cell_match),
        .hit     (hit),
        .hit_idx (hit_idx)
    );

    assign found   = (pend_find_reg && hit) ? fit_idx(hit_idx) : NO_POS;
    assign cnt_out = fit_cnt(occ_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_GROUP;
            end
            S_GROUP:
            begin
                state_next = S_RESOLVE;
            end
            S_RESOLVE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            occ_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
                occ_reg <= occ_next;
            if (state_reg == S_RESOLVE && out_free)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_status_reg <= status_next;
            pend_find_reg   <= (s_tuser == REQ_FIND);
        end
        if (state_reg == S_RESOLVE && out_free)
            m_tdata_reg <= {7'b0, empty, cnt_out, found, pend_status_reg};
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
